/* design/assert_macros.svh */
// Assertion macros shared by the ready queue modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PRQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define PRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/prq_pkg.sv */
// Types, codes and constants shared by the process ready queue.
package prq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int FIFO_DEPTH  = 2;
  localparam int FUNC_W      = 2;
  localparam int PID_W       = 16;
  localparam int PRIO_W      = 8;
  localparam int STATUS_W    = 2;
  localparam int COUNT_W     = 5;

  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd3;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_POP    = 2'd1,
    OP_QUERY  = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EMPTY     = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    op_t               op;
    logic [PID_W-1:0]  pid;
    logic [PRIO_W-1:0] prio;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_flags_t;

endpackage

/* design/prq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module prq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/prq_cmd_fifo.sv */
// Short command queue between the front end and the back end.
`include "assert_macros.svh"

module prq_cmd_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  prq_pkg::cmd_t        push_cmd,
  input  logic                 pop,
  output prq_pkg::cmd_t        head_cmd,
  output prq_pkg::fifo_flags_t flags
);

  localparam int DEPTH = prq_pkg::FIFO_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  prq_pkg::cmd_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] fill_r, fill_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + CW'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head_cmd    = mem_r[rd_ptr_r];
  assign flags.full  = (fill_r == CW'(DEPTH));
  assign flags.empty = (fill_r == '0);

  `PRQ_ASSERT(a_no_push_full, !(push && flags.full), "command pushed into full queue")
  `PRQ_ASSERT(a_no_pop_empty, !(pop && flags.empty), "command popped from empty queue")
  `PRQ_ASSERT_NEXT(a_push_fills, push && !pop, !flags.empty, "pushed command went missing")

endmodule

/* design/prq_front.sv */
// Front end: accepts commands and classifies the function code.
module prq_front (
  input  logic                         start,
  output logic                         busy,
  input  logic [prq_pkg::FUNC_W-1:0]   in_func,
  input  logic [prq_pkg::PID_W-1:0]    in_pid,
  input  logic [prq_pkg::PRIO_W-1:0]   in_priority_req,
  input  prq_pkg::fifo_flags_t         flags,
  output logic                         push,
  output prq_pkg::cmd_t                push_cmd
);

  prq_pkg::op_t op_s;

  always_comb begin
    unique case (in_func)
      prq_pkg::FUNC_APPEND: op_s = prq_pkg::OP_APPEND;
      prq_pkg::FUNC_POP:    op_s = prq_pkg::OP_POP;
      prq_pkg::FUNC_QUERY:  op_s = prq_pkg::OP_QUERY;
      prq_pkg::FUNC_REMOVE: op_s = prq_pkg::OP_REMOVE;
      default:              op_s = prq_pkg::OP_APPEND;
    endcase
  end

  // Hold off new commands while the queue to the back end is full.
  assign busy          = flags.full;
  assign push          = start && !flags.full;
  assign push_cmd.op   = op_s;
  assign push_cmd.pid  = in_pid;
  assign push_cmd.prio = in_priority_req;

endmodule

/* design/prq_back.sv */
// Back end: executes queue commands against the entry RAM.
`include "assert_macros.svh"

module prq_back #(
  parameter int QUEUE_DEPTH = prq_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  prq_pkg::cmd_t                 head_cmd,
  input  prq_pkg::fifo_flags_t          flags,
  output logic                          pop,
  output logic                          out_strobe,
  output logic [prq_pkg::STATUS_W-1:0]  out_status,
  output logic [prq_pkg::PID_W-1:0]     out_pid,
  output logic [prq_pkg::PRIO_W-1:0]    out_priority,
  output logic [prq_pkg::COUNT_W-1:0]   out_count
);

  localparam int IW      = $clog2(QUEUE_DEPTH);
  localparam int CW      = $clog2(QUEUE_DEPTH + 1);
  localparam int PID_W   = prq_pkg::PID_W;
  localparam int PRIO_W  = prq_pkg::PRIO_W;
  localparam int ENTRY_W = PID_W + PRIO_W;
  localparam int OUT_CW  = prq_pkg::COUNT_W;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_SCAN_RD  = 5'b00010,
    ST_SCAN_CHK = 5'b00100,
    ST_SHIFT_RD = 5'b01000,
    ST_SHIFT_WR = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  prq_pkg::op_t         op_r, op_nxt;
  logic [PID_W-1:0]     key_pid_r, key_pid_nxt;
  logic [PID_W-1:0]     best_pid_r, best_pid_nxt;
  logic [PRIO_W-1:0]    best_prio_r, best_prio_nxt;

  logic                 out_strobe_r;
  prq_pkg::status_t     out_status_r;
  logic [PID_W-1:0]     out_pid_r;
  logic [PRIO_W-1:0]    out_prio_r;
  logic [OUT_CW-1:0]    out_count_r;

  logic                 resp_valid;
  prq_pkg::status_t     resp_status;
  logic [PID_W-1:0]     resp_pid;
  logic [PRIO_W-1:0]    resp_prio;
  logic [CW-1:0]        resp_count;

  logic                 mem_we;
  logic [IW-1:0]        mem_waddr;
  logic [ENTRY_W-1:0]   mem_wdata;
  logic [IW-1:0]        mem_raddr;
  logic [ENTRY_W-1:0]   mem_rdata;

  logic [PID_W-1:0]     rd_pid;
  logic [PRIO_W-1:0]    rd_prio;
  logic                 last_s;
  logic                 take_s;
  logic                 more_s;

  prq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign rd_pid  = mem_rdata[ENTRY_W-1:PRIO_W];
  assign rd_prio = mem_rdata[PRIO_W-1:0];
  assign last_s  = (CW'(idx_r) + CW'(1)) >= count_r;
  assign more_s  = (CW'(idx_r) + CW'(1)) < count_r;
  assign take_s  = (idx_r == '0) || (rd_prio < best_prio_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    op_nxt        = op_r;
    key_pid_nxt   = key_pid_r;
    best_pid_nxt  = best_pid_r;
    best_prio_nxt = best_prio_r;
    pop           = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = mem_rdata;
    mem_raddr     = idx_r;
    resp_valid    = 1'b0;
    resp_status   = prq_pkg::STATUS_OK;
    resp_pid      = '0;
    resp_prio     = '0;
    resp_count    = count_r;

    unique case (state_r)
      ST_IDLE: begin
        if (!flags.empty) begin
          pop         = 1'b1;
          op_nxt      = head_cmd.op;
          key_pid_nxt = head_cmd.pid;
          idx_nxt     = '0;
          priority if (head_cmd.op == prq_pkg::OP_APPEND) begin
            resp_valid = 1'b1;
            if (count_r == CW'(QUEUE_DEPTH)) begin
              resp_status = prq_pkg::STATUS_FULL;
            end else begin
              mem_we     = 1'b1;
              mem_waddr  = count_r[IW-1:0];
              mem_wdata  = {head_cmd.pid, head_cmd.prio};
              count_nxt  = count_r + CW'(1);
              resp_pid   = head_cmd.pid;
              resp_prio  = head_cmd.prio;
              resp_count = count_r + CW'(1);
            end
          end else if (count_r == '0) begin
            resp_valid  = 1'b1;
            resp_status = prq_pkg::STATUS_EMPTY;
          end else begin
            state_nxt = ST_SCAN_RD;
          end
        end
      end

      ST_SCAN_RD: begin
        state_nxt = ST_SCAN_CHK;
      end

      ST_SCAN_CHK: begin
        unique case (op_r)
          prq_pkg::OP_POP: begin
            best_pid_nxt  = rd_pid;
            best_prio_nxt = rd_prio;
            state_nxt     = ST_SHIFT_RD;
          end
          prq_pkg::OP_QUERY: begin
            if (take_s) begin
              best_pid_nxt  = rd_pid;
              best_prio_nxt = rd_prio;
            end
            if (last_s) begin
              resp_valid = 1'b1;
              resp_pid   = take_s ? rd_pid : best_pid_r;
              resp_prio  = take_s ? rd_prio : best_prio_r;
              state_nxt  = ST_IDLE;
            end else begin
              idx_nxt   = idx_r + IW'(1);
              state_nxt = ST_SCAN_RD;
            end
          end
          prq_pkg::OP_REMOVE: begin
            if (rd_pid == key_pid_r) begin
              best_pid_nxt  = rd_pid;
              best_prio_nxt = rd_prio;
              state_nxt     = ST_SHIFT_RD;
            end else if (last_s) begin
              resp_valid  = 1'b1;
              resp_status = prq_pkg::STATUS_NOT_FOUND;
              state_nxt   = ST_IDLE;
            end else begin
              idx_nxt   = idx_r + IW'(1);
              state_nxt = ST_SCAN_RD;
            end
          end
          prq_pkg::OP_APPEND: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end

      // Close the gap: move each later entry up one place.
      ST_SHIFT_RD: begin
        if (more_s) begin
          mem_raddr = idx_r + IW'(1);
          state_nxt = ST_SHIFT_WR;
        end else begin
          count_nxt  = count_r - CW'(1);
          resp_valid = 1'b1;
          resp_pid   = best_pid_r;
          resp_prio  = best_prio_r;
          resp_count = count_r - CW'(1);
          state_nxt  = ST_IDLE;
        end
      end

      ST_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = mem_rdata;
        idx_nxt   = idx_r + IW'(1);
        state_nxt = ST_SHIFT_RD;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= resp_valid;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    op_r        <= op_nxt;
    key_pid_r   <= key_pid_nxt;
    best_pid_r  <= best_pid_nxt;
    best_prio_r <= best_prio_nxt;
    if (resp_valid) begin
      out_status_r <= resp_status;
      out_pid_r    <= resp_pid;
      out_prio_r   <= resp_prio;
      out_count_r  <= OUT_CW'(resp_count);
    end
  end

  assign out_strobe   = out_strobe_r;
  assign out_status   = out_status_r;
  assign out_pid      = out_pid_r;
  assign out_priority = out_prio_r;
  assign out_count    = out_count_r;

  `PRQ_ASSERT(a_count_bound, count_r <= CW'(QUEUE_DEPTH), "entry count above queue depth")
  `PRQ_ASSERT(a_write_in_range, !mem_we || (CW'(mem_waddr) < count_r) || (state_r == ST_IDLE), "entry write beyond valid entries")
  `PRQ_ASSERT_NEXT(a_full_flag, resp_valid && (resp_status == prq_pkg::STATUS_FULL), count_r == CW'(QUEUE_DEPTH), "full reported with free room")

endmodule

/* design/process_ready_queue.sv */
// Process ready queue: append, pop, most-urgent query and remove by pid over an ordered entry list.
//
// A command is taken when start is high and busy is low; up to two commands wait in a short
// queue between the front end and the back end, and busy stays high while that queue is full.
// Every command gives exactly one result, shown for one cycle with out_strobe; the receiver
// cannot stall it. Entries live in a single-port-read RAM that the back end walks one entry
// at a time, first setting the read address and then using the registered read data. Append
// and any command on an empty queue are answered straight from the idle state; a query
// scans every entry; pop takes the head entry and a remove scans for its pid, and when an
// entry is taken, the back end shifts each later entry up one place to close the gap.
module process_ready_queue #(
  parameter int QUEUE_DEPTH = prq_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [prq_pkg::FUNC_W-1:0]   in_func,
  input  logic [prq_pkg::PID_W-1:0]    in_pid,
  input  logic [prq_pkg::PRIO_W-1:0]   in_priority_req,
  output logic                         out_strobe,
  output logic [prq_pkg::STATUS_W-1:0] out_status,
  output logic [prq_pkg::PID_W-1:0]    out_pid,
  output logic [prq_pkg::PRIO_W-1:0]   out_priority,
  output logic [prq_pkg::COUNT_W-1:0]  out_count
);

  prq_pkg::fifo_flags_t flags;
  prq_pkg::cmd_t        push_cmd;
  prq_pkg::cmd_t        head_cmd;
  logic                 push;
  logic                 pop;

  prq_front u_front (
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_pid         (in_pid),
    .in_priority_req(in_priority_req),
    .flags          (flags),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  prq_cmd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head_cmd(head_cmd),
    .flags   (flags)
  );

  prq_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_cmd    (head_cmd),
    .flags       (flags),
    .pop         (pop),
    .out_strobe  (out_strobe),
    .out_status  (out_status),
    .out_pid     (out_pid),
    .out_priority(out_priority),
    .out_count   (out_count)
  );

endmodule
